[hdl/sorted_delay_queue_assert.svh]
// Assertion macros used by the sorted delay queue checker.
`ifndef SORTED_DELAY_QUEUE_ASSERT_SVH
`define SORTED_DELAY_QUEUE_ASSERT_SVH

// Same-cycle implication, skipped while reset is held.
`define SDQ_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sorted delay queue check failed");

// Next-cycle implication, skipped while reset is held.
`define SDQ_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sorted delay queue check failed");

`endif

[hdl/sdq_pkg.sv]
// Types and constants shared by the sorted delay queue modules.
package sdq_pkg;

    localparam int DEF_DEPTH    = 16;
    localparam int DEF_ID_BITS  = 8;
    localparam int DEF_KEY_BITS = 32;

    localparam int KIND_BITS   = 3;
    localparam int STATUS_BITS = 3;

    localparam logic [KIND_BITS-1:0] KIND_INS_FRONT = 3'd0;
    localparam logic [KIND_BITS-1:0] KIND_INS_BACK  = 3'd1;
    localparam logic [KIND_BITS-1:0] KIND_INS_SORT  = 3'd2;
    localparam logic [KIND_BITS-1:0] KIND_REM_FRONT = 3'd3;
    localparam logic [KIND_BITS-1:0] KIND_REM_BACK  = 3'd4;
    localparam logic [KIND_BITS-1:0] KIND_REM_ITEM  = 3'd5;

    localparam logic [STATUS_BITS-1:0] ST_DONE   = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY  = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_DUP    = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_FULL   = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_ABSENT = 3'd4;

    // Which cell marks the operation point (first marking cell wins).
    typedef enum logic [2:0] {
        HIT_FRONT,
        HIT_COUNT,
        HIT_LAST,
        HIT_GT,
        HIT_ID
    } t_hit;

    typedef struct packed {
        logic cmp_en;
        logic upd_en;
        logic ins;
        logic rem;
        t_hit hit;
    } t_cell_ctl;

    typedef struct packed {
        logic le;
        logic gt_last;
        logic idm;
    } t_cell_flag;

endpackage

[hdl/sdq_cell.sv]
// One queue position: holds an entry, compares it and shifts with its neighbors.
module sdq_cell #(
    parameter int ID_BITS  = 8,
    parameter int KEY_BITS = 32,
    parameter int CNT_BITS = 5,
    parameter int POS      = 0
) (
    input  logic                 i_clk,
    input  sdq_pkg::t_cell_ctl   i_ctl,
    input  logic [CNT_BITS-1:0]  i_count,
    input  logic [ID_BITS-1:0]   i_new_id,
    input  logic [KEY_BITS-1:0]  i_new_key,
    input  logic [ID_BITS-1:0]   i_left_id,
    input  logic [KEY_BITS-1:0]  i_left_key,
    input  logic [ID_BITS-1:0]   i_right_id,
    input  logic [KEY_BITS-1:0]  i_right_key,
    input  logic                 i_pre,
    output logic                 o_pre,
    output sdq_pkg::t_cell_flag  o_flag,
    output logic [ID_BITS-1:0]   o_id,
    output logic [KEY_BITS-1:0]  o_key,
    output logic [ID_BITS-1:0]   o_take
);
    import sdq_pkg::*;

    localparam logic [CNT_BITS-1:0] P = CNT_BITS'(POS);

    logic [ID_BITS-1:0]  r_id;
    logic [KEY_BITS-1:0] r_key;
    logic [ID_BITS-1:0]  n_id;
    logic [KEY_BITS-1:0] n_key;
    logic                r_gt;
    logic                r_le;
    logic                r_idm;
    logic                r_gt_last;
    logic                occ;
    logic                last;
    logic                hit;
    logic                at;

    assign occ  = P < i_count;
    assign last = P == (i_count - CNT_BITS'(1));

    always_comb begin
        unique case (i_ctl.hit)
            HIT_FRONT: hit = (P == '0);
            HIT_COUNT: hit = (P == i_count);
            HIT_LAST:  hit = last;
            HIT_GT:    hit = r_gt;
            HIT_ID:    hit = r_idm;
            default:   hit = 1'b0;
        endcase
    end

    assign at    = hit & ~i_pre;
    assign o_pre = i_pre | hit;

    // Insert: take the new entry at the point, shift right after it.
    // Remove: pull from the right neighbor at and after the point.
    always_comb begin
        n_id  = r_id;
        n_key = r_key;
        if (i_ctl.ins) begin
            if (at) begin
                n_id  = i_new_id;
                n_key = i_new_key;
            end else if (i_pre) begin
                n_id  = i_left_id;
                n_key = i_left_key;
            end
        end else if (i_ctl.rem) begin
            if (at || i_pre) begin
                n_id  = i_right_id;
                n_key = i_right_key;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp_en) begin
            r_gt      <= occ && (i_new_key < r_key);
            r_le      <= i_new_key <= r_key;
            r_idm     <= occ && (i_new_id == r_id);
            r_gt_last <= last && (i_new_key < r_key);
        end
        if (i_ctl.upd_en) begin
            r_id  <= n_id;
            r_key <= n_key;
        end
    end

    assign o_flag.le      = r_le;
    assign o_flag.gt_last = r_gt_last;
    assign o_flag.idm     = r_idm;
    assign o_id           = r_id;
    assign o_key          = r_key;
    assign o_take         = (i_ctl.rem && at) ? r_id : '0;

endmodule

[hdl/sorted_delay_queue.sv]
// Sorted delay queue: ordered entry queue built from a chain of shifting cells.
//
// Input channel: i_valid / o_stall carry one item (i_kind, i_item_id, i_key);
// the item is taken at a clock edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall carry one result per item (o_status,
// o_removed_id, o_count, o_head_valid, o_head_id, o_head_key).
// Position 0 of the cell chain is the front of the queue.
//
// Each taken item passes through a compare state, which registers key and
// id compares in every cell, then an update state, which resolves the
// operation point along the chain, shifts the cells and registers the
// result with o_valid. The next item is taken on the same edge that commits
// the current one; no new item is taken between the compare and the commit.
//
// While the receiver stalls, the result and the queue contents hold; one more
// item may be taken and compared, then o_stall stays high until the result
// leaves. Reset empties the queue (count zero) and drops any pending result;
// entry contents are not cleared and are never shown while unoccupied.
module sorted_delay_queue #(
    parameter int DEPTH    = sdq_pkg::DEF_DEPTH,
    parameter int ID_BITS  = sdq_pkg::DEF_ID_BITS,
    parameter int KEY_BITS = sdq_pkg::DEF_KEY_BITS,
    parameter int CNT_BITS = $clog2(DEPTH + 1)
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [sdq_pkg::KIND_BITS-1:0]    i_kind,
    input  logic [ID_BITS-1:0]               i_item_id,
    input  logic [KEY_BITS-1:0]              i_key,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [sdq_pkg::STATUS_BITS-1:0]  o_status,
    output logic [ID_BITS-1:0]               o_removed_id,
    output logic [CNT_BITS-1:0]              o_count,
    output logic                             o_head_valid,
    output logic [ID_BITS-1:0]               o_head_id,
    output logic [KEY_BITS-1:0]              o_head_key
);
    import sdq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD
    } t_state;

    t_state                  r_state;
    logic                    r_out_valid;
    logic [STATUS_BITS-1:0]  r_status;
    logic [ID_BITS-1:0]      r_removed;
    logic [CNT_BITS-1:0]     r_count;
    logic [KIND_BITS-1:0]    r_kind;
    logic [ID_BITS-1:0]      r_id;
    logic [KEY_BITS-1:0]     r_key;

    t_cell_ctl               w_ctl;
    t_cell_flag              w_flag [DEPTH];
    logic [ID_BITS-1:0]      w_id   [DEPTH];
    logic [KEY_BITS-1:0]     w_key  [DEPTH];
    logic [ID_BITS-1:0]      w_take [DEPTH];
    logic                    w_pre  [DEPTH+1];

    logic                    commit;
    logic                    accept;
    logic                    any_idm;
    logic                    gt_last;
    logic [ID_BITS-1:0]      removed;
    logic [STATUS_BITS-1:0]  status;
    logic                    do_ins;
    logic                    do_rem;
    t_hit                    hit;

    assign commit  = (r_state == S_UPD) && (!r_out_valid || !i_stall);
    assign o_stall = !((r_state == S_IDLE) || commit);
    assign accept  = i_valid && !o_stall;

    always_comb begin
        any_idm = 1'b0;
        gt_last = 1'b0;
        removed = '0;
        for (int i = 0; i < DEPTH; i++) begin
            any_idm = any_idm | w_flag[i].idm;
            gt_last = gt_last | w_flag[i].gt_last;
            removed = removed | w_take[i];
        end
    end

    always_comb begin
        status = ST_DONE;
        do_ins = 1'b0;
        do_rem = 1'b0;
        hit    = HIT_FRONT;
        unique case (r_kind) inside
            KIND_INS_FRONT, KIND_INS_BACK, KIND_INS_SORT: begin
                if (any_idm) begin
                    status = ST_DUP;
                end else if (r_count == CNT_BITS'(DEPTH)) begin
                    status = ST_FULL;
                end else begin
                    do_ins = 1'b1;
                    if (r_count == '0 || r_kind == KIND_INS_FRONT) begin
                        hit = HIT_FRONT;
                    end else if (r_kind == KIND_INS_BACK) begin
                        hit = HIT_COUNT;
                    end else if (w_flag[0].le) begin
                        hit = HIT_FRONT;
                    end else if (!gt_last) begin
                        hit = HIT_COUNT;
                    end else begin
                        hit = HIT_GT;
                    end
                end
            end
            KIND_REM_FRONT, KIND_REM_BACK, KIND_REM_ITEM: begin
                if (r_count == '0) begin
                    status = ST_EMPTY;
                end else if (r_kind == KIND_REM_FRONT) begin
                    do_rem = 1'b1;
                    hit    = HIT_FRONT;
                end else if (r_kind == KIND_REM_BACK) begin
                    do_rem = 1'b1;
                    hit    = HIT_LAST;
                end else if (any_idm) begin
                    do_rem = 1'b1;
                    hit    = HIT_ID;
                end else begin
                    status = ST_ABSENT;
                end
            end
            default: begin
                status = ST_DONE;
            end
        endcase
    end

    assign w_ctl.cmp_en = (r_state == S_CMP);
    assign w_ctl.upd_en = commit;
    assign w_ctl.ins    = do_ins;
    assign w_ctl.rem    = do_rem;
    assign w_ctl.hit    = hit;

    assign w_pre[0] = 1'b0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        localparam int LI = (g == 0) ? 0 : g - 1;
        localparam int RI = (g == DEPTH - 1) ? g : g + 1;

        sdq_cell #(
            .ID_BITS  (ID_BITS),
            .KEY_BITS (KEY_BITS),
            .CNT_BITS (CNT_BITS),
            .POS      (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_count     (r_count),
            .i_new_id    (r_id),
            .i_new_key   (r_key),
            .i_left_id   (w_id[LI]),
            .i_left_key  (w_key[LI]),
            .i_right_id  (w_id[RI]),
            .i_right_key (w_key[RI]),
            .i_pre       (w_pre[g]),
            .o_pre       (w_pre[g+1]),
            .o_flag      (w_flag[g]),
            .o_id        (w_id[g]),
            .o_key       (w_key[g]),
            .o_take      (w_take[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (accept) begin
                r_kind <= i_kind;
                r_id   <= i_item_id;
                r_key  <= i_key;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (commit) begin
                        r_state <= accept ? S_CMP : S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (commit) begin
                r_out_valid <= 1'b1;
                r_status    <= status;
                r_removed   <= removed;
                if (do_ins) begin
                    r_count <= r_count + CNT_BITS'(1);
                end else if (do_rem) begin
                    r_count <= r_count - CNT_BITS'(1);
                end
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_status;
    assign o_removed_id = r_removed;
    assign o_count      = r_count;
    assign o_head_valid = (r_count != '0);
    assign o_head_id    = o_head_valid ? w_id[0] : '0;
    assign o_head_key   = o_head_valid ? w_key[0] : '0;

endmodule

[hdl/sdq_checker.sv]
// Port-level checker for the sorted delay queue, bound to the top level.
`include "sorted_delay_queue_assert.svh"

module sdq_checker #(
    parameter int DEPTH    = sdq_pkg::DEF_DEPTH,
    parameter int ID_BITS  = sdq_pkg::DEF_ID_BITS,
    parameter int CNT_BITS = $clog2(DEPTH + 1)
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_valid,
    input logic                             i_stall,
    input logic [sdq_pkg::STATUS_BITS-1:0]  o_status,
    input logic [ID_BITS-1:0]               o_removed_id,
    input logic [CNT_BITS-1:0]              o_count,
    input logic                             o_head_valid
);
    import sdq_pkg::*;

    `SDQ_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, o_valid, o_count <= CNT_BITS'(DEPTH))

    `SDQ_ASSERT_NOW(a_head_matches_count, i_clk, i_rst_n, o_valid, o_head_valid == (o_count != '0))

    `SDQ_ASSERT_NOW(a_empty_removes_nothing, i_clk, i_rst_n, o_valid && o_status == ST_EMPTY, o_removed_id == '0 && o_count == '0)

    `SDQ_ASSERT_NEXT(a_stalled_result_holds, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_status) && $stable(o_count))

endmodule

bind sorted_delay_queue sdq_checker #(
    .DEPTH    (DEPTH),
    .ID_BITS  (ID_BITS),
    .CNT_BITS (CNT_BITS)
) u_sdq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_status     (o_status),
    .o_removed_id (o_removed_id),
    .o_count      (o_count),
    .o_head_valid (o_head_valid)
);
